@@ design/sdkm_pkg.sv @@
`timescale 1ns / 1ps

package sdkm_pkg;

	localparam int unsigned DEPTH_DEF   = 64;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [31:0] record_key;
		logic [15:0] grade;
		logic        last_record;
	} record_t;

	typedef struct packed {
		logic [31:0] out_key;
		logic [15:0] out_grade;
		logic        last_result;
		logic        overflow;
	} result_t;

	// classified record handed from the front to the back
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] grade;
		logic        store;
		logic        last;
		logic        ovf;
	} cmd_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] grade;
	} entry_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_TAIL,
		ST_END
	} back_state_t;

endpackage

@@ design/sdkm_front.sv @@
`timescale 1ns / 1ps

module sdkm_front #(
	parameter int unsigned DEPTH = sdkm_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sdkm_pkg::record_t record,
	input  logic              q_full,
	output logic              q_push,
	output sdkm_pkg::cmd_t    cmd
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          room;

	assign full   = q_full;
	assign q_push = push & ~q_full;
	assign room   = (cnt_q < CW'(DEPTH));

	always_comb begin
		cmd.key   = record.record_key;
		cmd.grade = record.grade;
		cmd.store = room;
		cmd.last  = record.last_record;
		cmd.ovf   = ovf_q | ~room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (q_push) begin
			if (record.last_record) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

@@ design/sdkm_queue.sv @@
`timescale 1ns / 1ps

module sdkm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  sdkm_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd,
	output sdkm_pkg::cmd_t rd_data,
	output logic           empty
);

	sdkm_pkg::cmd_t                    slot_q [sdkm_pkg::QUEUE_DEPTH];
	logic [sdkm_pkg::QUEUE_AW-1:0]     wp_q;
	logic [sdkm_pkg::QUEUE_AW-1:0]     rp_q;
	logic [sdkm_pkg::QUEUE_CW-1:0]     cnt_q;
	logic                              do_wr;
	logic                              do_rd;

	assign full    = (cnt_q == sdkm_pkg::QUEUE_CW'(sdkm_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~empty;
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + sdkm_pkg::QUEUE_AW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + sdkm_pkg::QUEUE_AW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + sdkm_pkg::QUEUE_CW'(1);
				2'b01:   cnt_q <= cnt_q - sdkm_pkg::QUEUE_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/sdkm_back.sv @@
`timescale 1ns / 1ps

module sdkm_back #(
	parameter int unsigned DEPTH = sdkm_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sdkm_pkg::cmd_t    cmd,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output sdkm_pkg::result_t result
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sdkm_pkg::back_state_t state_q, state_d;

	sdkm_pkg::entry_t mem [DEPTH];
	sdkm_pkg::entry_t rd_s1;
	logic             valid_s1;

	logic [CW-1:0] wr_q;
	logic [AW-1:0] addr_q;
	logic          found_q;
	logic          have_prev_q;
	logic          ovf_q;
	logic          out_valid_q;
	logic [31:0]   best_key_q;
	logic [15:0]   best_grade_q;
	logic [31:0]   prev_key_q;
	logic [15:0]   pend_grade_q;
	sdkm_pkg::result_t out_q;

	logic mem_we;
	logic rd_en;
	logic start_pass;
	logic take_best;
	logic emit;
	logic emit_last;
	logic finish;
	logic load_last;
	logic can_emit;
	logic cand;

	assign empty    = ~out_valid_q;
	assign result   = out_q;
	assign can_emit = ~out_valid_q | pop;
	assign cand     = ~have_prev_q | (rd_s1.key > prev_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdkm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		start_pass = 1'b0;
		take_best  = 1'b0;
		emit       = 1'b0;
		emit_last  = 1'b0;
		finish     = 1'b0;
		load_last  = 1'b0;
		unique case (state_q)
			sdkm_pkg::ST_LOAD: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					mem_we = cmd.store;
					if (cmd.last) begin
						load_last  = 1'b1;
						start_pass = 1'b1;
						state_d    = sdkm_pkg::ST_SCAN;
					end
				end
			end
			sdkm_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if ((CW'(addr_q) + CW'(1)) >= wr_q) begin
					state_d = sdkm_pkg::ST_TAIL;
				end
			end
			sdkm_pkg::ST_TAIL: begin
				state_d = sdkm_pkg::ST_END;
			end
			sdkm_pkg::ST_END: begin
				if (have_prev_q) begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_last = ~found_q;
						if (found_q) begin
							take_best  = 1'b1;
							start_pass = 1'b1;
							state_d    = sdkm_pkg::ST_SCAN;
						end else begin
							finish  = 1'b1;
							state_d = sdkm_pkg::ST_LOAD;
						end
					end
				end else if (found_q) begin
					take_best  = 1'b1;
					start_pass = 1'b1;
					state_d    = sdkm_pkg::ST_SCAN;
				end else begin
					finish  = 1'b1;
					state_d = sdkm_pkg::ST_LOAD;
				end
			end
			default: state_d = sdkm_pkg::ST_LOAD;
		endcase
	end

	// record memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_q[AW-1:0]] <= '{key: cmd.key, grade: cmd.grade};
		end
		if (rd_en) begin
			rd_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			addr_q      <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (finish) begin
				wr_q <= '0;
			end else if (mem_we) begin
				wr_q <= wr_q + CW'(1);
			end
			if (load_last) begin
				ovf_q <= cmd.ovf;
			end
			if (start_pass) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					addr_q <= addr_q + AW'(1);
				end
				if (valid_s1 && cand) begin
					found_q <= 1'b1;
				end
			end
			if (finish) begin
				have_prev_q <= 1'b0;
			end else if (take_best) begin
				have_prev_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// running minimum above the previous key, largest grade among its copies
	always_ff @(posedge clk) begin
		if (valid_s1 && cand) begin
			if (!found_q || (rd_s1.key < best_key_q)) begin
				best_key_q   <= rd_s1.key;
				best_grade_q <= rd_s1.grade;
			end else if ((rd_s1.key == best_key_q) && (rd_s1.grade > best_grade_q)) begin
				best_grade_q <= rd_s1.grade;
			end
		end
		if (take_best) begin
			prev_key_q   <= best_key_q;
			pend_grade_q <= best_grade_q;
		end
		if (emit) begin
			out_q.out_key     <= prev_key_q;
			out_q.out_grade   <= pend_grade_q;
			out_q.last_result <= emit_last;
			out_q.overflow    <= ovf_q;
		end
	end

endmodule

@@ design/sort_dedupe_keep_max_core.sv @@
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------------
// record    | push / full            | record_key, grade, last_record
// result    | pop / empty            | out_key, out_grade, last_result, overflow
//
// records enter a four-entry queue one a cycle unless full, then the record memory
// after the last record of a set, with n held and p distinct keys, the set takes p + 1
// scan passes over the n held records, one memory read a cycle on the single read port
// during that time the queue fills and full rises; records past the depth are dropped
// a stalled result holds the scan at the end of a pass until it is popped
// reset clears counters, queue and result valid; the memory contents are not cleared

module sort_dedupe_keep_max_core #(
	parameter int unsigned DEPTH = sdkm_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sdkm_pkg::record_t record,
	output logic              empty,
	input  logic              pop,
	output sdkm_pkg::result_t result
);

	sdkm_pkg::cmd_t q_wr_data;
	sdkm_pkg::cmd_t q_rd_data;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;

	sdkm_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.record (record),
		.q_full (q_full),
		.q_push (q_push),
		.cmd    (q_wr_data)
	);

	sdkm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	sdkm_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.cmd     (q_rd_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("front pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("back popped an empty queue");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting transaction changed before it was popped");

endmodule
